[rtl/imbe_pkg.sv]
// Package for the I2C master bit engine: item types, opcodes and constants.
package imbe_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned BIDX_W    = 4;

  // Phase length after reset, in ticks
  localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd50;

  // Command opcodes; codes above OP_READ_NACK are ignored
  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_WRITE     = 3'd2,
    OP_READ_ACK  = 3'd3,
    OP_READ_NACK = 3'd4
  } imbe_op_t;

  // Input item: one bus tick
  typedef struct packed {
    logic                 cmd_valid;
    logic [2:0]           opcode;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 sda_in;
  } imbe_in_t;

  // Result item: line drive and status after the tick
  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 ack_seen;
  } imbe_out_t;

endpackage

[rtl/imbe_seq.sv]
// Bus sequencer of the I2C master: phase state machine, bit counter and shifters.
module imbe_seq
  import imbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic [TICK_W-1:0] phase_ticks_i,
  input  imbe_in_t          item_i,
  output imbe_out_t         res_o
);

  typedef enum logic [14:0] {
    PH_IDLE    = 15'b000000000000001,
    PH_ST_A    = 15'b000000000000010,
    PH_ST_B    = 15'b000000000000100,
    PH_SP_A    = 15'b000000000001000,
    PH_SP_B    = 15'b000000000010000,
    PH_WR_LOW  = 15'b000000000100000,
    PH_WR_HIGH = 15'b000000001000000,
    PH_WA_LOW  = 15'b000000010000000,
    PH_WA_HIGH = 15'b000000100000000,
    PH_WA_TAIL = 15'b000001000000000,
    PH_RD_PRE  = 15'b000010000000000,
    PH_RD_HIGH = 15'b000100000000000,
    PH_RD_LOW  = 15'b001000000000000,
    PH_RK_LOW  = 15'b010000000000000,
    PH_RK_HIGH = 15'b100000000000000
  } phase_t;

  phase_t               phase_r,      phase_nxt;
  logic [TICK_W-1:0]    tick_count_r, tick_count_nxt;
  logic [BIDX_W-1:0]    bit_index_r,  bit_index_nxt;
  logic [BYTE_BITS-1:0] shift_reg_r,  shift_reg_nxt;
  logic [BYTE_BITS-1:0] rx_reg_r,     rx_reg_nxt;
  logic                 scl_r,        scl_nxt;
  logic                 sda_r,        sda_nxt;
  logic                 ack_r,        ack_nxt;
  logic                 send_nack_r,  send_nack_nxt;
  logic                 done;

  logic [TICK_W-1:0]    limit;
  logic [TICK_W-1:0]    tick_inc;
  logic [BIDX_W-1:0]    bit_inc;
  logic [BYTE_BITS-1:0] shift_sh;

  localparam logic [BIDX_W-1:0] BIT_LAST = BIDX_W'(BYTE_BITS);

  // A zero phase length counts as one tick
  assign limit    = (phase_ticks_i == '0) ? TICK_W'(1) : phase_ticks_i;
  assign tick_inc = tick_count_r + TICK_W'(1);
  assign bit_inc  = bit_index_r + BIDX_W'(1);
  assign shift_sh = {shift_reg_r[BYTE_BITS-2:0], 1'b0};

  // Next-state logic for one tick
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    bit_index_nxt  = bit_index_r;
    shift_reg_nxt  = shift_reg_r;
    rx_reg_nxt     = rx_reg_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_nxt        = ack_r;
    send_nack_nxt  = send_nack_r;
    done           = 1'b0;

    if (phase_r == PH_IDLE) begin
      // Commands are taken only here; the accepting tick drives the first phase
      if (item_i.cmd_valid) begin
        case (item_i.opcode)
          OP_START: begin
            bit_index_nxt = '0;
            phase_nxt = PH_ST_A; scl_nxt = 1'b1; sda_nxt = 1'b1; tick_count_nxt = '0;
          end
          OP_STOP: begin
            bit_index_nxt = '0;
            phase_nxt = PH_SP_A; scl_nxt = 1'b0; sda_nxt = 1'b0; tick_count_nxt = '0;
          end
          OP_WRITE: begin
            bit_index_nxt = '0;
            shift_reg_nxt = item_i.tx_byte;
            phase_nxt = PH_WR_LOW; scl_nxt = 1'b0;
            sda_nxt = item_i.tx_byte[BYTE_BITS-1]; tick_count_nxt = '0;
          end
          OP_READ_ACK, OP_READ_NACK: begin
            bit_index_nxt = '0;
            send_nack_nxt = (item_i.opcode == OP_READ_NACK);
            shift_reg_nxt = '0;
            phase_nxt = PH_RD_PRE; scl_nxt = 1'b0; sda_nxt = 1'b1; tick_count_nxt = '0;
          end
          default: ;
        endcase
      end
    end else begin
      tick_count_nxt = tick_inc;
      if (tick_inc >= limit) begin
        tick_count_nxt = '0;
        case (phase_r)
          PH_ST_A: begin
            phase_nxt = PH_ST_B; scl_nxt = 1'b1; sda_nxt = 1'b0;
          end
          PH_SP_A: begin
            phase_nxt = PH_SP_B; scl_nxt = 1'b1; sda_nxt = 1'b0;
          end
          PH_WR_LOW: begin
            phase_nxt = PH_WR_HIGH; scl_nxt = 1'b1;
          end
          PH_WR_HIGH: begin
            bit_index_nxt = bit_inc;
            shift_reg_nxt = shift_sh;
            if (bit_inc < BIT_LAST) begin
              phase_nxt = PH_WR_LOW; scl_nxt = 1'b0; sda_nxt = shift_sh[BYTE_BITS-1];
            end else begin
              phase_nxt = PH_WA_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1;
            end
          end
          PH_WA_LOW: begin
            phase_nxt = PH_WA_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1;
          end
          PH_WA_HIGH: begin
            // Slave ACK is the line pulled low at the end of the high phase
            ack_nxt = ~item_i.sda_in;
            phase_nxt = PH_WA_TAIL; scl_nxt = 1'b0; sda_nxt = 1'b1;
          end
          PH_RD_PRE: begin
            phase_nxt = PH_RD_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1;
          end
          PH_RD_HIGH: begin
            shift_reg_nxt = {shift_reg_r[BYTE_BITS-2:0], item_i.sda_in};
            bit_index_nxt = bit_inc;
            phase_nxt = PH_RD_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1;
          end
          PH_RD_LOW: begin
            if (bit_index_r < BIT_LAST) begin
              phase_nxt = PH_RD_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1;
            end else begin
              phase_nxt = PH_RK_LOW; scl_nxt = 1'b0; sda_nxt = send_nack_r;
            end
          end
          PH_RK_LOW: begin
            phase_nxt = PH_RK_HIGH; scl_nxt = 1'b1; sda_nxt = send_nack_r;
          end
          PH_ST_B: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b0; done = 1'b1;
          end
          PH_SP_B: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b1; sda_nxt = 1'b1; done = 1'b1;
          end
          PH_WA_TAIL: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b1; done = 1'b1;
          end
          PH_RK_HIGH: begin
            rx_reg_nxt = shift_reg_r;
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = send_nack_r; done = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // State registers, advanced once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      bit_index_r  <= '0;
      shift_reg_r  <= '0;
      rx_reg_r     <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_r        <= 1'b0;
      send_nack_r  <= 1'b0;
    end else if (step_i) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_reg_r  <= shift_reg_nxt;
      rx_reg_r     <= rx_reg_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_r        <= ack_nxt;
      send_nack_r  <= send_nack_nxt;
    end
  end

  // Result reflects the state after this tick
  assign res_o.scl_level = scl_nxt;
  assign res_o.sda_level = sda_nxt;
  assign res_o.busy_res  = (phase_nxt != PH_IDLE);
  assign res_o.done_res  = done;
  assign res_o.rx_byte   = rx_reg_nxt;
  assign res_o.ack_seen  = ack_nxt;

`ifndef SYNTHESIS
  // Completion only ends a command that was in progress
  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && done) |-> (phase_r != PH_IDLE))
    else $error("done without a command in progress");

  // Bit counter never runs past one byte
  a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_index_r <= BIT_LAST)
    else $error("bit index beyond byte length");

  // Received byte only updates when a read completes
  a_rx_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && !done) |=> $stable(rx_reg_r))
    else $error("rx byte changed outside read completion");

  // A valid command in idle always starts a sequence
  a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && phase_r == PH_IDLE && item_i.cmd_valid &&
     (item_i.opcode == OP_START || item_i.opcode == OP_STOP ||
      item_i.opcode == OP_WRITE || item_i.opcode == OP_READ_ACK ||
      item_i.opcode == OP_READ_NACK))
    |=> (phase_r != PH_IDLE))
    else $error("command in idle did not start");
`endif

endmodule

[rtl/i2c_master_bit_engine.sv]
// Top level of the I2C master bit engine: channel registers, config register, sequencer.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+-------------------
//  in       | in_valid, in_stall, in_item        | valid & !stall
//  out      | out_valid, out_stall, out_item     | valid & !stall
//  cfg      | cfg_valid, cfg_ready, cfg_data     | valid & ready
//
// One item (one bus tick) per cycle while the output is not stalled; an item's
// result passes from the input register through the sequencer logic into the
// result register, from which it leaves.
// Synchronous active-low reset: lines released, phase length 50 ticks.
// A stalled result holds; one further item is taken into the input register.
module i2c_master_bit_engine
  import imbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  imbe_in_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output imbe_out_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TICK_W-1:0] cfg_data
);

  logic              in_valid_r;
  imbe_in_t          in_item_r;
  logic              out_valid_r;
  imbe_out_t         out_item_r;
  logic [TICK_W-1:0] phase_ticks_r;
  logic              advance;
  logic              step;
  imbe_out_t         res;

  // Result register frees up when empty or being taken
  assign advance   = !out_valid_r || !out_stall;
  assign step      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  // Phase length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks_r <= cfg_data;
    end
  end

  imbe_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        (step),
    .phase_ticks_i (phase_ticks_r),
    .item_i        (in_item_r),
    .res_o         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[bench/i2c_master_bit_engine_tb.sv]
// Self-checking testbench for the I2C master bit engine: line timing, byte shifting and status.
module i2c_master_bit_engine_tb;
  import imbe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES   = 2_000_000;
  localparam int unsigned IDLE_PCT       = 29;
  localparam int unsigned PRINT_CAP      = 30;
  localparam int unsigned TICKS_PER_STEP = 50;
  localparam int unsigned LONG_PHASE     = 24;
  localparam logic [2:0]  OP_LAST_CODE   = 3'b111;

  // Sequencer phases of the bench's own engine copy
  typedef enum logic [3:0] {
    E_IDLE, E_START_HI, E_START_LO, E_STOP_LO, E_STOP_HI,
    E_WBIT_LO, E_WBIT_HI, E_WACK_LO, E_WACK_HI, E_WACK_TAIL,
    E_RD_SETUP, E_RBIT_HI, E_RBIT_LO, E_RACK_LO, E_RACK_HI
  } eng_phase_t;

  // How the slave side drives SDA on each item
  typedef enum logic [1:0] {SDA_RAND, SDA_LOW, SDA_HIGH} sda_mode_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  imbe_in_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  imbe_out_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TICK_W-1:0] cfg_data  = '0;

  i2c_master_bit_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Engine copy: state and configuration
  eng_phase_t        eng_phase;
  logic [TICK_W-1:0] eng_count;
  logic [TICK_W-1:0] cfg_phase_len;
  logic [BIDX_W-1:0] eng_bit;
  logic [7:0]        eng_shift;
  logic [7:0]        eng_rx;
  logic              eng_scl;
  logic              eng_sda;
  logic              eng_ack;
  logic              eng_nack;

  imbe_out_t   line_results_q[$];
  int unsigned errors     = 0;
  int unsigned ticks_sent = 0;
  int unsigned cycles     = 0;
  bit          quiet      = 1'b0;
  sda_mode_t   sda_mode   = SDA_RAND;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
  endtask

  task automatic eng_enter(input eng_phase_t ph, input logic scl, input logic sda);
    eng_phase = ph;
    eng_scl   = scl;
    eng_sda   = sda;
    eng_count = '0;
  endtask

  task automatic reset_engine();
    cfg_phase_len = PHASE_TICKS_RST;
    eng_phase     = E_IDLE;
    eng_count     = '0;
    eng_bit       = '0;
    eng_shift     = '0;
    eng_rx        = '0;
    eng_scl       = 1'b1;
    eng_sda       = 1'b1;
    eng_ack       = 1'b0;
    eng_nack      = 1'b0;
  endtask

  // Advance the engine copy by one tick and queue the line state it produces
  task automatic engine_tick(input imbe_in_t it);
    imbe_out_t         res;
    logic [TICK_W-1:0] lim;
    logic              fin;
    lim = (cfg_phase_len == '0) ? TICK_W'(1) : cfg_phase_len;
    fin = 1'b0;
    if (eng_phase == E_IDLE) begin
      if (it.cmd_valid && it.opcode <= OP_READ_NACK) begin
        eng_bit = '0;
        case (it.opcode)
          OP_START: eng_enter(E_START_HI, 1'b1, 1'b1);
          OP_STOP:  eng_enter(E_STOP_LO, 1'b0, 1'b0);
          OP_WRITE: begin
            eng_shift = it.tx_byte;
            eng_enter(E_WBIT_LO, 1'b0, eng_shift[7]);
          end
          default: begin
            eng_nack  = (it.opcode == OP_READ_NACK);
            eng_shift = '0;
            eng_enter(E_RD_SETUP, 1'b0, 1'b1);
          end
        endcase
      end
    end else begin
      eng_count = eng_count + 1'b1;
      if (eng_count >= lim) begin
        case (eng_phase)
          E_START_HI: eng_enter(E_START_LO, 1'b1, 1'b0);
          E_STOP_LO:  eng_enter(E_STOP_HI, 1'b1, 1'b0);
          E_WBIT_LO:  eng_enter(E_WBIT_HI, 1'b1, eng_sda);
          E_WBIT_HI: begin
            eng_bit   = eng_bit + 1'b1;
            eng_shift = eng_shift << 1;
            if (eng_bit < BYTE_BITS) eng_enter(E_WBIT_LO, 1'b0, eng_shift[7]);
            else eng_enter(E_WACK_LO, 1'b0, 1'b1);
          end
          E_WACK_LO: eng_enter(E_WACK_HI, 1'b1, 1'b1);
          E_WACK_HI: begin
            eng_ack = ~it.sda_in;
            eng_enter(E_WACK_TAIL, 1'b0, 1'b1);
          end
          E_RD_SETUP: eng_enter(E_RBIT_HI, 1'b1, 1'b1);
          E_RBIT_HI: begin
            eng_shift = {eng_shift[6:0], it.sda_in};
            eng_bit   = eng_bit + 1'b1;
            eng_enter(E_RBIT_LO, 1'b0, 1'b1);
          end
          E_RBIT_LO: begin
            if (eng_bit < BYTE_BITS) eng_enter(E_RBIT_HI, 1'b1, 1'b1);
            else eng_enter(E_RACK_LO, 1'b0, eng_nack);
          end
          E_RACK_LO: eng_enter(E_RACK_HI, 1'b1, eng_nack);
          E_START_LO: begin
            eng_enter(E_IDLE, 1'b0, 1'b0);
            fin = 1'b1;
          end
          E_STOP_HI: begin
            eng_enter(E_IDLE, 1'b1, 1'b1);
            fin = 1'b1;
          end
          E_WACK_TAIL: begin
            eng_enter(E_IDLE, 1'b0, 1'b1);
            fin = 1'b1;
          end
          E_RACK_HI: begin
            eng_rx = eng_shift;
            eng_enter(E_IDLE, 1'b0, eng_nack);
            fin = 1'b1;
          end
          default: eng_enter(E_IDLE, eng_scl, eng_sda);
        endcase
      end
    end
    res.scl_level = eng_scl;
    res.sda_level = eng_sda;
    res.busy_res  = (eng_phase != E_IDLE);
    res.done_res  = fin;
    res.rx_byte   = eng_rx;
    res.ack_seen  = eng_ack;
    line_results_q.push_back(res);
  endtask

  function automatic imbe_in_t make_tick(input logic v, input logic [2:0] op, input logic [7:0] b);
    imbe_in_t it;
    it.cmd_valid = v;
    it.opcode    = op;
    it.tx_byte   = b;
    case (sda_mode)
      SDA_LOW:  it.sda_in = 1'b0;
      SDA_HIGH: it.sda_in = 1'b1;
      default:  it.sda_in = 1'($urandom_range(1));
    endcase
    return it;
  endfunction

  // Offer one item, with random gaps, and hold it until the block takes it
  task automatic send_tick(input imbe_in_t it);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    engine_tick(it);
    ticks_sent++;
  endtask

  // Issue a command on an idle engine and clock it to completion; busy ticks carry noise
  task automatic run_cmd(input imbe_op_t op, input logic [7:0] b);
    send_tick(make_tick(1'b1, op, b));
    while (eng_phase != E_IDLE)
      send_tick(make_tick(1'($urandom_range(3) == 0), 3'($urandom_range(7)), 8'($urandom)));
  endtask

  // Wait until every queued result has come back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [TICK_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cfg_phase_len = v;
  endtask

  // Start and stop conditions at the phase length left by reset
  task automatic test_default_phase();
    run_cmd(OP_START, 8'h00);
    run_cmd(OP_STOP, 8'h00);
  endtask

  // Unused opcodes and invalid ticks leave the engine idle
  task automatic test_ignored_codes();
    for (int c = int'(OP_READ_NACK) + 1; c <= int'(OP_LAST_CODE); c++)
      send_tick(make_tick(1'b1, 3'(c), 8'($urandom)));
    for (int c = 0; c <= int'(OP_LAST_CODE); c++)
      send_tick(make_tick(1'b0, 3'(c), 8'($urandom)));
  endtask

  // Zero length (taken as one) and one tick: every command, byte extremes, ACK and NACK
  task automatic test_short_phase();
    for (int s = 0; s < 2; s++) begin
      write_cfg(TICK_W'(s));
      run_cmd(OP_START, 8'h00);
      sda_mode = SDA_LOW;
      run_cmd(OP_WRITE, 8'h00);
      run_cmd(OP_READ_ACK, 8'hFF);
      sda_mode = SDA_HIGH;
      run_cmd(OP_WRITE, 8'hFF);
      run_cmd(OP_READ_NACK, 8'h00);
      sda_mode = SDA_RAND;
      run_cmd(OP_WRITE, 8'h80);
      run_cmd(OP_WRITE, 8'h01);
      run_cmd(OP_READ_ACK, 8'h00);
      run_cmd(OP_STOP, 8'h00);
    end
  endtask

  // Longer phase length: a start condition held at full count, no gaps
  task automatic test_max_phase();
    write_cfg(TICK_W'(LONG_PHASE));
    quiet = 1'b1;
    run_cmd(OP_START, 8'h00);
    quiet = 1'b0;
  endtask

  task automatic random_transfer();
    int unsigned n;
    n = $urandom_range(1, 3);
    run_cmd(OP_START, 8'h00);
    run_cmd(OP_WRITE, 8'($urandom));
    repeat (n) begin
      case ($urandom_range(2))
        0: run_cmd(OP_WRITE, 8'($urandom));
        1: run_cmd(OP_READ_ACK, 8'($urandom));
        default: run_cmd(OP_READ_NACK, 8'($urandom));
      endcase
    end
    run_cmd(OP_STOP, 8'h00);
  endtask

  // Mostly well-formed transfers, some lone commands, unused codes and empty ticks
  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned pick;
    for (int step = 0; step < 5; step++) begin
      case (step)
        0: write_cfg(TICK_W'(1));
        1: write_cfg('0);
        2: write_cfg(TICK_W'($urandom_range(2, 4)));
        3: write_cfg(TICK_W'($urandom_range(1, 5)));
        default: write_cfg(TICK_W'(3));
      endcase
      quiet = (step == 0);
      goal  = ticks_sent + TICKS_PER_STEP;
      while (ticks_sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          random_transfer();
        end else if (pick < 85) begin
          run_cmd(imbe_op_t'($urandom_range(int'(OP_READ_NACK))), 8'($urandom));
        end else if (pick < 93) begin
          send_tick(make_tick(1'b1, 3'($urandom_range(int'(OP_READ_NACK) + 1,
                                                      int'(OP_LAST_CODE))), 8'($urandom)));
        end else begin
          repeat ($urandom_range(1, 4))
            send_tick(make_tick(1'b0, 3'($urandom_range(7)), 8'($urandom)));
        end
      end
      quiet = 1'b0;
    end
  endtask

  // Result side: compare each taken item, then pick the next stall
  always @(posedge clk) begin
    imbe_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (line_results_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = line_results_q.pop_front();
        check_field("scl_level", 8'(out_item.scl_level), 8'(want.scl_level));
        check_field("sda_level", 8'(out_item.sda_level), 8'(want.sda_level));
        check_field("busy_res", 8'(out_item.busy_res), 8'(want.busy_res));
        check_field("done_res", 8'(out_item.done_res), 8'(want.done_res));
        check_field("rx_byte", out_item.rx_byte, want.rx_byte);
        check_field("ack_seen", 8'(out_item.ack_seen), 8'(want.ack_seen));
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    reset_engine();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_phase();
    test_ignored_codes();
    test_short_phase();
    test_max_phase();
    test_random_traffic();
    drain();
    if (errors == 0 && line_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/imbe_pkg.sv
rtl/imbe_seq.sv
rtl/i2c_master_bit_engine.sv
bench/i2c_master_bit_engine_tb.sv
